>>> rtl/sio_pkg.sv
// Shared types and constants for the segment crossing / overlap test.
// No dependencies; used by the top level and its checker.
package sio_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned RegW     = 21;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned NumTests = 4;
  localparam int unsigned Depth    = 8;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoordW:0]   dif_t;
  typedef logic signed [2*CoordW+1:0] prod_t;
  typedef logic signed [2*CoordW+2:0] sum_t;
  typedef logic [RegW-1:0]          reg_t;
  typedef logic [2*RegW-1:0]        sq_t;
  typedef logic [67:0]              pp_t;
  typedef logic [135:0]             wide_t;

  localparam logic [CfgIdxW-1:0] CfgNearDist = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMinOvl   = 2'd1;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } sio_in_t;

  typedef struct packed {
    logic crosses;
    logic overlaps;
    logic degenerate;
  } sio_out_t;

  function automatic dif_t diff(coord_t a, coord_t b);
    return dif_t'(a) - dif_t'(b);
  endfunction

endpackage

>>> rtl/segment_intersect_overlap_test_unit.sv
// Segment crossing and overlap test, eight-stage pipeline.
// Depends on sio_pkg.
//
// Throughput: one pair per cycle while the output is not stalled.
// Each stage moves on when it is empty or its successor moves, so bubbles close up.
// Reset clears all stage valid bits and loads the configuration registers with
// 0.2 (near distance) and 0.5 (minimum overlap length) in the coordinate format.
module segment_intersect_overlap_test_unit #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sio_pkg::sio_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sio_pkg::sio_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [sio_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  sio_pkg::reg_t                 cfg_data_i
);

  // reset values, clamped to the register width
  localparam longint unsigned RegMax  = (64'd1 << sio_pkg::RegW) - 64'd1;
  localparam longint unsigned NearRaw = (64'd1 << COORD_FRAC_BITS) / 5;
  localparam longint unsigned MinRaw  = 64'd1 << (COORD_FRAC_BITS - 1);
  localparam sio_pkg::reg_t NearRst =
    sio_pkg::reg_t'((NearRaw > RegMax) ? RegMax : NearRaw);
  localparam sio_pkg::reg_t MinRst =
    sio_pkg::reg_t'((MinRaw > RegMax) ? RegMax : MinRaw);
  localparam int unsigned NT = sio_pkg::NumTests;

  // ---------------------------------------------------------------
  // Configuration registers (user writes only while the pipe is empty; not enforced)
  // ---------------------------------------------------------------
  sio_pkg::reg_t near_q, minl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= NearRst;
      minl_q <= MinRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sio_pkg::CfgNearDist: near_q <= cfg_data_i;
        sio_pkg::CfgMinOvl:   minl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Stage control: valid bits and per-stage enables
  // ---------------------------------------------------------------
  logic [8:1] v_q;
  logic [8:1] en;

  always_comb begin
    en[8] = !v_q[8] || !out_stall_i;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= 8; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = v_q[8];

  // ---------------------------------------------------------------
  // Stage 1: coordinate differences, collinear rule, degenerate flag.
  // Tests 0..3: B start / B end against A, A start / A end against B.
  // w = point - segment start, q = point - segment end.
  // ---------------------------------------------------------------
  sio_pkg::dif_t s1_rx_q, s1_ry_q, s1_sx_q, s1_sy_q;
  sio_pkg::dif_t s1_wx_q [NT];
  sio_pkg::dif_t s1_wy_q [NT];
  sio_pkg::dif_t s1_qx_q [NT];
  sio_pkg::dif_t s1_qy_q [NT];
  logic          s1_coll_q, s1_degen_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_rx_q <= sio_pkg::diff(in_data_i.a_end_x, in_data_i.a_start_x);
      s1_ry_q <= sio_pkg::diff(in_data_i.a_end_y, in_data_i.a_start_y);
      s1_sx_q <= sio_pkg::diff(in_data_i.b_end_x, in_data_i.b_start_x);
      s1_sy_q <= sio_pkg::diff(in_data_i.b_end_y, in_data_i.b_start_y);
      s1_wx_q[0] <= sio_pkg::diff(in_data_i.b_start_x, in_data_i.a_start_x);
      s1_wy_q[0] <= sio_pkg::diff(in_data_i.b_start_y, in_data_i.a_start_y);
      s1_qx_q[0] <= sio_pkg::diff(in_data_i.b_start_x, in_data_i.a_end_x);
      s1_qy_q[0] <= sio_pkg::diff(in_data_i.b_start_y, in_data_i.a_end_y);
      s1_wx_q[1] <= sio_pkg::diff(in_data_i.b_end_x, in_data_i.a_start_x);
      s1_wy_q[1] <= sio_pkg::diff(in_data_i.b_end_y, in_data_i.a_start_y);
      s1_qx_q[1] <= sio_pkg::diff(in_data_i.b_end_x, in_data_i.a_end_x);
      s1_qy_q[1] <= sio_pkg::diff(in_data_i.b_end_y, in_data_i.a_end_y);
      s1_wx_q[2] <= sio_pkg::diff(in_data_i.a_start_x, in_data_i.b_start_x);
      s1_wy_q[2] <= sio_pkg::diff(in_data_i.a_start_y, in_data_i.b_start_y);
      s1_qx_q[2] <= sio_pkg::diff(in_data_i.a_start_x, in_data_i.b_end_x);
      s1_qy_q[2] <= sio_pkg::diff(in_data_i.a_start_y, in_data_i.b_end_y);
      s1_wx_q[3] <= sio_pkg::diff(in_data_i.a_end_x, in_data_i.b_start_x);
      s1_wy_q[3] <= sio_pkg::diff(in_data_i.a_end_y, in_data_i.b_start_y);
      s1_qx_q[3] <= sio_pkg::diff(in_data_i.a_end_x, in_data_i.b_end_x);
      s1_qy_q[3] <= sio_pkg::diff(in_data_i.a_end_y, in_data_i.b_end_y);
      // B start on the line through A: straddle test per axis
      s1_coll_q <=
        ((in_data_i.b_start_x < in_data_i.a_start_x) !=
         (in_data_i.b_start_x < in_data_i.a_end_x)) ||
        ((in_data_i.b_start_y < in_data_i.a_start_y) !=
         (in_data_i.b_start_y < in_data_i.a_end_y));
      s1_degen_q <=
        ((in_data_i.a_start_x == in_data_i.a_end_x) &&
         (in_data_i.a_start_y == in_data_i.a_end_y)) ||
        ((in_data_i.b_start_x == in_data_i.b_end_x) &&
         (in_data_i.b_start_y == in_data_i.b_end_y));
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: squared thresholds and 33x33 products
  // ---------------------------------------------------------------
  sio_pkg::dif_t tdx [NT];
  sio_pkg::dif_t tdy [NT];

  always_comb begin
    for (int k = 0; k < NT; k++) begin
      tdx[k] = (k < 2) ? s1_rx_q : s1_sx_q;
      tdy[k] = (k < 2) ? s1_ry_q : s1_sy_q;
    end
  end

  sio_pkg::prod_t s2_wda_q [NT];
  sio_pkg::prod_t s2_wdb_q [NT];
  sio_pkg::prod_t s2_wwa_q [NT];
  sio_pkg::prod_t s2_wwb_q [NT];
  sio_pkg::prod_t s2_qqa_q [NT];
  sio_pkg::prod_t s2_qqb_q [NT];
  sio_pkg::prod_t s2_cra_q [NT];
  sio_pkg::prod_t s2_crb_q [NT];
  sio_pkg::prod_t s2_rra_q, s2_rrb_q, s2_ssa_q, s2_ssb_q;
  sio_pkg::prod_t s2_csa_q, s2_csb_q, s2_rsa_q, s2_rsb_q;
  sio_pkg::prod_t s2_x2a_q, s2_x2b_q, s2_x4a_q, s2_x4b_q;
  sio_pkg::sq_t   s2_th2_q, s2_lim2_q;
  logic           s2_coll_q, s2_degen_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int k = 0; k < NT; k++) begin
        s2_wda_q[k] <= s1_wx_q[k] * tdx[k];
        s2_wdb_q[k] <= s1_wy_q[k] * tdy[k];
        s2_wwa_q[k] <= s1_wx_q[k] * s1_wx_q[k];
        s2_wwb_q[k] <= s1_wy_q[k] * s1_wy_q[k];
        s2_qqa_q[k] <= s1_qx_q[k] * s1_qx_q[k];
        s2_qqb_q[k] <= s1_qy_q[k] * s1_qy_q[k];
        s2_cra_q[k] <= s1_wx_q[k] * tdy[k];
        s2_crb_q[k] <= s1_wy_q[k] * tdx[k];
      end
      s2_rra_q   <= s1_rx_q * s1_rx_q;
      s2_rrb_q   <= s1_ry_q * s1_ry_q;
      s2_ssa_q   <= s1_sx_q * s1_sx_q;
      s2_ssb_q   <= s1_sy_q * s1_sy_q;
      s2_csa_q   <= s1_wx_q[0] * s1_sy_q;
      s2_csb_q   <= s1_wy_q[0] * s1_sx_q;
      s2_rsa_q   <= s1_rx_q * s1_sy_q;
      s2_rsb_q   <= s1_ry_q * s1_sx_q;
      // dot products for A seen from its end point (negated later)
      s2_x2a_q   <= s1_qx_q[0] * s1_rx_q;
      s2_x2b_q   <= s1_qy_q[0] * s1_ry_q;
      s2_x4a_q   <= s1_qx_q[1] * s1_rx_q;
      s2_x4b_q   <= s1_qy_q[1] * s1_ry_q;
      s2_th2_q   <= sio_pkg::sq_t'(near_q) * sio_pkg::sq_t'(near_q);
      s2_lim2_q  <= sio_pkg::sq_t'(minl_q) * sio_pkg::sq_t'(minl_q);
      s2_coll_q  <= s1_coll_q;
      s2_degen_q <= s1_degen_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: dot and cross product sums
  // ---------------------------------------------------------------
  sio_pkg::sum_t s3_wd_q [NT];
  sio_pkg::sum_t s3_ww_q [NT];
  sio_pkg::sum_t s3_qq_q [NT];
  sio_pkg::sum_t s3_cr_q [NT];
  sio_pkg::sum_t s3_dda_q, s3_ddb_q, s3_cs_q, s3_rs_q, s3_x2_q, s3_x4_q;
  sio_pkg::sq_t  s3_th2_q, s3_lim2_q;
  logic          s3_coll_q, s3_degen_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int k = 0; k < NT; k++) begin
        s3_wd_q[k] <= sio_pkg::sum_t'(s2_wda_q[k]) + sio_pkg::sum_t'(s2_wdb_q[k]);
        s3_ww_q[k] <= sio_pkg::sum_t'(s2_wwa_q[k]) + sio_pkg::sum_t'(s2_wwb_q[k]);
        s3_qq_q[k] <= sio_pkg::sum_t'(s2_qqa_q[k]) + sio_pkg::sum_t'(s2_qqb_q[k]);
        s3_cr_q[k] <= sio_pkg::sum_t'(s2_cra_q[k]) - sio_pkg::sum_t'(s2_crb_q[k]);
      end
      s3_dda_q   <= sio_pkg::sum_t'(s2_rra_q) + sio_pkg::sum_t'(s2_rrb_q);
      s3_ddb_q   <= sio_pkg::sum_t'(s2_ssa_q) + sio_pkg::sum_t'(s2_ssb_q);
      s3_cs_q    <= sio_pkg::sum_t'(s2_csa_q) - sio_pkg::sum_t'(s2_csb_q);
      s3_rs_q    <= sio_pkg::sum_t'(s2_rsa_q) - sio_pkg::sum_t'(s2_rsb_q);
      s3_x2_q    <= sio_pkg::sum_t'(s2_x2a_q) + sio_pkg::sum_t'(s2_x2b_q);
      s3_x4_q    <= sio_pkg::sum_t'(s2_x4a_q) + sio_pkg::sum_t'(s2_x4b_q);
      s3_th2_q   <= s2_th2_q;
      s3_lim2_q  <= s2_lim2_q;
      s3_coll_q  <= s2_coll_q;
      s3_degen_q <= s2_degen_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: crossing decision, region of each point, partial products
  // of cross^2 and near^2 * |d|^2
  // ---------------------------------------------------------------
  sio_pkg::sum_t tdd [NT];
  sio_pkg::sum_t tcra [NT];
  sio_pkg::pp_t  tcru [NT];
  sio_pkg::pp_t  tddu [NT];
  logic          cross_d;

  always_comb begin
    for (int k = 0; k < NT; k++) begin
      tdd[k]  = (k < 2) ? s3_dda_q : s3_ddb_q;
      tcra[k] = (s3_cr_q[k] < 0) ? -s3_cr_q[k] : s3_cr_q[k];
      tcru[k] = {1'b0, tcra[k]};
      tddu[k] = {1'b0, tdd[k]};
    end
    if (s3_cr_q[0] == 0) begin
      cross_d = s3_coll_q;
    end else if (s3_rs_q > 0) begin
      cross_d = (s3_cs_q >= 0) && (s3_cs_q <= s3_rs_q) &&
                (s3_cr_q[0] >= 0) && (s3_cr_q[0] <= s3_rs_q);
    end else if (s3_rs_q < 0) begin
      cross_d = (s3_cs_q <= 0) && (s3_cs_q >= s3_rs_q) &&
                (s3_cr_q[0] <= 0) && (s3_cr_q[0] >= s3_rs_q);
    end else begin
      cross_d = 1'b0;
    end
  end

  logic [NT-1:0] s4_zero_q, s4_bef_q, s4_aft_q, s4_nw_q, s4_nq_q;
  sio_pkg::pp_t  s4_cll_q [NT];
  sio_pkg::pp_t  s4_clh_q [NT];
  sio_pkg::pp_t  s4_chh_q [NT];
  sio_pkg::pp_t  s4_tll_q [NT];
  sio_pkg::pp_t  s4_tlh_q [NT];
  sio_pkg::pp_t  s4_thl_q [NT];
  sio_pkg::pp_t  s4_thh_q [NT];
  logic [65:0]   s4_dda_q, s4_ddb_q;
  sio_pkg::sum_t s4_wd0_q, s4_wd1_q, s4_x2_q, s4_x4_q;
  sio_pkg::sq_t  s4_lim2_q;
  logic          s4_cross_q, s4_degen_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int k = 0; k < NT; k++) begin
        s4_zero_q[k] <= (tdd[k] == 0);
        s4_bef_q[k]  <= (s3_wd_q[k] < 0);
        s4_aft_q[k]  <= (s3_wd_q[k] > tdd[k]);
        s4_nw_q[k]   <= (s3_ww_q[k] < sio_pkg::sum_t'(s3_th2_q));
        s4_nq_q[k]   <= (s3_qq_q[k] < sio_pkg::sum_t'(s3_th2_q));
        s4_cll_q[k]  <= tcru[k][33:0] * tcru[k][33:0];
        s4_clh_q[k]  <= tcru[k][33:0] * tcru[k][67:34];
        s4_chh_q[k]  <= tcru[k][67:34] * tcru[k][67:34];
        s4_tll_q[k]  <= s3_th2_q[33:0] * tddu[k][33:0];
        s4_tlh_q[k]  <= s3_th2_q[33:0] * tddu[k][67:34];
        s4_thl_q[k]  <= s3_th2_q[41:34] * tddu[k][33:0];
        s4_thh_q[k]  <= s3_th2_q[41:34] * tddu[k][67:34];
      end
      s4_dda_q   <= s3_dda_q[65:0];
      s4_ddb_q   <= s3_ddb_q[65:0];
      s4_wd0_q   <= s3_wd_q[0];
      s4_wd1_q   <= s3_wd_q[1];
      s4_x2_q    <= s3_x2_q;
      s4_x4_q    <= s3_x4_q;
      s4_lim2_q  <= s3_lim2_q;
      s4_cross_q <= cross_d;
      s4_degen_q <= s3_degen_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 5: endpoint matches
  // ---------------------------------------------------------------
  sio_pkg::wide_t tcr2 [NT];
  sio_pkg::wide_t tthd [NT];
  logic [NT-1:0]  match_d;

  always_comb begin
    for (int k = 0; k < NT; k++) begin
      tcr2[k] = sio_pkg::wide_t'(s4_cll_q[k]) + (sio_pkg::wide_t'(s4_clh_q[k]) << 35) +
                (sio_pkg::wide_t'(s4_chh_q[k]) << 68);
      tthd[k] = sio_pkg::wide_t'(s4_tll_q[k]) + (sio_pkg::wide_t'(s4_tlh_q[k]) << 34) +
                (sio_pkg::wide_t'(s4_thl_q[k]) << 34) +
                (sio_pkg::wide_t'(s4_thh_q[k]) << 68);
      if (s4_zero_q[k])     match_d[k] = 1'b0;
      else if (s4_bef_q[k]) match_d[k] = s4_nw_q[k];
      else if (s4_aft_q[k]) match_d[k] = s4_nq_q[k];
      else                  match_d[k] = (tcr2[k] < tthd[k]);
    end
  end

  logic [NT-1:0] s5_m_q;
  logic [65:0]   s5_dda_q, s5_ddb_q;
  sio_pkg::sum_t s5_wd0_q, s5_wd1_q, s5_x2_q, s5_x4_q;
  sio_pkg::sq_t  s5_lim2_q;
  logic          s5_cross_q, s5_degen_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_m_q     <= match_d;
      s5_dda_q   <= s4_dda_q;
      s5_ddb_q   <= s4_ddb_q;
      s5_wd0_q   <= s4_wd0_q;
      s5_wd1_q   <= s4_wd1_q;
      s5_x2_q    <= s4_x2_q;
      s5_x4_q    <= s4_x4_q;
      s5_lim2_q  <= s4_lim2_q;
      s5_cross_q <= s4_cross_q;
      s5_degen_q <= s4_degen_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 6: match count rules, pick the one-sided projection
  // match bits: 0 B start on A, 1 B end on A, 2 A start on B, 3 A end on B
  // ---------------------------------------------------------------
  logic signed [67:0] wsel;
  logic [66:0]        wu;
  sio_pkg::pp_t       wpp, ddap, ddbp;
  logic               early_t, early_f, reject, f10;

  always_comb begin
    if (s5_m_q[2]) begin
      wsel = s5_m_q[0] ? 68'(s5_wd0_q) : 68'(s5_wd1_q);
    end else begin
      wsel = s5_m_q[0] ? -68'(s5_x2_q) : -68'(s5_x4_q);
    end
    wu      = wsel[66:0];
    wpp     = {1'b0, wu};
    ddap    = {2'b00, s5_dda_q};
    ddbp    = {2'b00, s5_ddb_q};
    early_t = ($countones(s5_m_q) > 2) || (s5_m_q[0] && s5_m_q[1]) ||
              (s5_m_q[2] && s5_m_q[3]);
    early_f = !((s5_m_q[0] || s5_m_q[1]) && (s5_m_q[2] || s5_m_q[3]));
    reject  = (wsel < 0) || (wsel > $signed({1'b0, s5_dda_q, 1'b0}));
    f10     = ((72'(wu) * 72'd10) >= (72'(s5_dda_q) * 72'd9));
  end

  sio_pkg::pp_t s6_wll_q, s6_wlh_q, s6_whh_q;
  sio_pkg::pp_t s6_lll_q, s6_llh_q, s6_lhl_q, s6_lhh_q;
  sio_pkg::pp_t s6_bll_q, s6_blh_q, s6_bhl_q, s6_bhh_q;
  logic         s6_et_q, s6_ef_q, s6_rej_q, s6_f10_q, s6_cross_q, s6_degen_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_wll_q   <= wpp[33:0] * wpp[33:0];
      s6_wlh_q   <= wpp[33:0] * wpp[67:34];
      s6_whh_q   <= wpp[67:34] * wpp[67:34];
      s6_lll_q   <= s5_lim2_q[33:0] * ddap[33:0];
      s6_llh_q   <= s5_lim2_q[33:0] * ddap[67:34];
      s6_lhl_q   <= s5_lim2_q[41:34] * ddap[33:0];
      s6_lhh_q   <= s5_lim2_q[41:34] * ddap[67:34];
      s6_bll_q   <= ddap[33:0] * ddbp[33:0];
      s6_blh_q   <= ddap[33:0] * ddbp[67:34];
      s6_bhl_q   <= ddap[67:34] * ddbp[33:0];
      s6_bhh_q   <= ddap[67:34] * ddbp[67:34];
      s6_et_q    <= early_t;
      s6_ef_q    <= early_f;
      s6_rej_q   <= reject;
      s6_f10_q   <= f10;
      s6_cross_q <= s5_cross_q;
      s6_degen_q <= s5_degen_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 7: assemble the wide products
  // ---------------------------------------------------------------
  sio_pkg::wide_t s7_w2_q, s7_l2dd_q, s7_ddbb_q;
  logic           s7_et_q, s7_ef_q, s7_rej_q, s7_f10_q, s7_cross_q, s7_degen_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_w2_q    <= sio_pkg::wide_t'(s6_wll_q) + (sio_pkg::wide_t'(s6_wlh_q) << 35) +
                    (sio_pkg::wide_t'(s6_whh_q) << 68);
      s7_l2dd_q  <= sio_pkg::wide_t'(s6_lll_q) + (sio_pkg::wide_t'(s6_llh_q) << 34) +
                    (sio_pkg::wide_t'(s6_lhl_q) << 34) +
                    (sio_pkg::wide_t'(s6_lhh_q) << 68);
      s7_ddbb_q  <= sio_pkg::wide_t'(s6_bll_q) + (sio_pkg::wide_t'(s6_blh_q) << 34) +
                    (sio_pkg::wide_t'(s6_bhl_q) << 34) +
                    (sio_pkg::wide_t'(s6_bhh_q) << 68);
      s7_et_q    <= s6_et_q;
      s7_ef_q    <= s6_ef_q;
      s7_rej_q   <= s6_rej_q;
      s7_f10_q   <= s6_f10_q;
      s7_cross_q <= s6_cross_q;
      s7_degen_q <= s6_degen_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 8: length tests and output register
  // ---------------------------------------------------------------
  logic long_d, ratio_d, ovl_d;
  sio_pkg::sio_out_t s8_q;

  always_comb begin
    long_d  = (s7_w2_q > s7_l2dd_q);
    ratio_d = ((143'(s7_w2_q) * 143'd100) >= (143'(s7_ddbb_q) * 143'd81));
    ovl_d   = !s7_degen_q &&
              (s7_et_q || (!s7_ef_q && !s7_rej_q && (long_d || s7_f10_q || ratio_d)));
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_q.crosses    <= s7_cross_q;
      s8_q.overlaps   <= ovl_d;
      s8_q.degenerate <= s7_degen_q;
    end
  end

  assign out_data_o = s8_q;

endmodule

>>> rtl/sio_checker.sv
// Port-level checks for the segment crossing / overlap unit, bound to the top level.
// Depends on sio_pkg.
module sio_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input sio_pkg::sio_out_t           out_data_o,
  input logic                        cfg_we_i
);

  logic [3:0] cnt_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // transactions in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> !out_data_o.overlaps)
    else $error("overlap reported for a degenerate pair");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'(sio_pkg::Depth))
    else $error("more transactions in flight than pipeline stages");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> cnt_q == 4'd0)
    else $error("register written with transactions in flight");

endmodule

bind segment_intersect_overlap_test_unit sio_checker u_sio_checker (.*);
